// ----- rtl/core/sprite_animation_sequencer_defines.svh -----
// Assertion helpers for the sprite animation sequencer.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sas_pkg.sv -----
package sas_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_WALK_DEF    = 1024;

  localparam int WORD_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TOTAL_W  = 32;

  localparam logic signed [WORD_W-1:0] WORD_RESTART = -16'sd999;
  localparam logic signed [WORD_W-1:0] WORD_STOP    = -16'sd101;
  localparam logic signed [WORD_W-1:0] WORD_JUMP    = -16'sd100;
  localparam logic [16:0]              JUMP_BIAS    = 17'd100;

  localparam logic [7:0]  BASE_DELAY_RST    = 8'd1;
  localparam logic [15:0] AUTO_RESTART_RST  = 16'd210;
  localparam logic [15:0] STOP_NOTICE_RST   = 16'd140;
  localparam logic [7:0]  MANUAL_NOTICE_RST = 8'd70;
  localparam logic [7:0]  SLOW_FACTOR_RST   = 8'd2;

  typedef enum logic [3:0] {
    KIND_TICK       = 4'd0,
    KIND_WRITE      = 4'd1,
    KIND_RESTART    = 4'd2,
    KIND_MANUAL     = 4'd3,
    KIND_STEP_FWD   = 4'd4,
    KIND_STEP_BACK  = 4'd5,
    KIND_SLOW_ON    = 4'd6,
    KIND_SLOW_OFF   = 4'd7,
    KIND_PAUSE      = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    CFG_BASE_DELAY    = 3'd0,
    CFG_AUTO_RESTART  = 3'd1,
    CFG_STOP_NOTICE   = 3'd2,
    CFG_MANUAL_NOTICE = 3'd3,
    CFG_SLOW_FACTOR   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESTART,
    S_WALK_RD,
    S_WALK_EV,
    S_TICK,
    S_TICK_TAIL,
    S_BACK_RD,
    S_BACK_EV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WM_RESET,
    WM_TICK,
    WM_STEP
  } walk_mode_t;

endpackage

// ----- rtl/core/sprite_animation_sequencer.sv -----
// Sprite animation sequencer. Each request on the slave stream is one event
// (tick, table write, restart, manual restart, step forward/back, slow motion
// on/off, pause toggle) and yields exactly one response on the master stream
// carrying the shown sprite, its table position, stop/notice flags, the
// saturating tick count, a redraw flag and a walk overflow flag. Commands live
// in a single-port-write, registered-read table RAM that one small sequencer
// walks one word at a time: every command looked at passes through an address
// state and then an evaluate state. A table write, a mode change or an unused
// kind goes straight to the final state, as does a held or paused tick from the
// tick state; an advancing tick may walk W commands (W at most MAX_WALK), as may
// a step forward; a restart (plain, manual or automatic) adds its own walk; a
// step back scans positions backwards until it finds a frame or reaches 0.
// s_tready is high only while the sequencer is idle; the response register
// frees the sequencer as soon as the response is loaded, and a response still
// waiting on m_tready holds the sequencer in its final state. The table comes
// up unwritten and needs no clearing. TABLE_DEPTH must be a power of two.
`include "sprite_animation_sequencer_defines.svh"

module sprite_animation_sequencer #(
  parameter int TABLE_DEPTH = sas_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_WALK    = sas_pkg::MAX_WALK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // table_index[7:0], table_word[23:8]
  input  logic [4:0]                    s_tuser,   // kind[3:0], hold[4]
  // response stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // sprite_index[15:0],
                                                   // shown_position[24:16], stopped[25],
                                                   // restart_notice[26],
                                                   // elapsed_ticks[58:27], redraw[59],
                                                   // walk_overflow[60], zero above
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [sas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sas_pkg::CFG_W-1:0]     cfg_data
);
  import sas_pkg::*;

  localparam int POS_W  = $clog2(TABLE_DEPTH);
  localparam int SLOT_W = POS_W + 1;
  localparam int LEFT_W = $clog2(MAX_WALK + 1);

  // configuration registers
  logic [7:0]  base_delay;
  logic [15:0] auto_restart;
  logic [15:0] stop_notice;
  logic [7:0]  manual_notice;
  logic [7:0]  slow_factor;

  // sequencer and playback state
  state_t                   state, state_next;
  walk_mode_t               mode, mode_next;
  logic                     ret_tick, ret_tick_next;
  kind_t                    kind_r, kind_r_next;
  logic                     hold_r, hold_r_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic [15:0]              cur_delay, cur_delay_next;
  logic [15:0]              dtimer, dtimer_next;
  logic signed [15:0]       sprite, sprite_next;
  logic signed [SLOT_W-1:0] slot, slot_next;
  logic [15:0]              stop_cnt, stop_cnt_next;
  logic [7:0]               notice_cnt, notice_cnt_next;
  logic                     slow_on, slow_on_next;
  logic [7:0]               slow_cnt, slow_cnt_next;
  logic                     pause_on, pause_on_next;
  logic [TOTAL_W-1:0]       total, total_next;
  logic [LEFT_W-1:0]        left, left_next;
  logic [POS_W-1:0]         back_i, back_i_next;
  logic                     redraw, redraw_next;
  logic                     ovf, ovf_next;

  // request fields
  logic               s_fire;
  kind_t              in_kind;
  logic               in_hold;
  logic [7:0]         in_index;
  logic [15:0]        in_word;

  assign s_fire   = s_tvalid && s_tready;
  assign in_kind  = kind_t'(s_tuser[3:0]);
  assign in_hold  = s_tuser[4];
  assign in_index = s_tdata[7:0];
  assign in_word  = s_tdata[23:8];
  assign s_tready = (state == S_IDLE);

  // table RAM
  logic                     ram_we;
  logic [POS_W-1:0]         ram_raddr;
  logic signed [WORD_W-1:0] wd;

  assign ram_we    = s_fire && (in_kind == KIND_WRITE);
  assign ram_raddr = (state == S_BACK_RD) ? back_i : pos;

  sas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (POS_W'(in_index)),
    .wdata (in_word),
    .raddr (ram_raddr),
    .rdata (wd)
  );

  // command decode of the word just read
  logic        w_frame, w_restart, w_stop, w_jump;
  logic [16:0] jump_dist;
  logic        walk_fin, walk_ovf, walk_end;

  assign w_frame   = !wd[15];
  assign w_restart = (wd == WORD_RESTART);
  assign w_stop    = (wd == WORD_STOP);
  assign w_jump    = (wd <= WORD_JUMP);
  assign jump_dist = 17'(-{wd[15], wd}) - JUMP_BIAS;
  assign walk_fin  = w_frame || (w_stop && mode != WM_STEP);
  assign walk_ovf  = !walk_fin && (left == LEFT_W'(1));
  assign walk_end  = walk_fin || walk_ovf;

  // tick decisions
  logic [15:0] stop_inc;
  logic [7:0]  slow_inc;
  logic        tick_skip, tick_restart, slow_wait, timer_wait;
  logic [15:0] hold_time;
  logic        back_end;
  logic        out_free;

  assign stop_inc     = (stop_cnt == 16'hFFFF) ? stop_cnt : stop_cnt + 16'd1;
  assign slow_inc     = (slow_cnt == 8'hFF) ? slow_cnt : slow_cnt + 8'd1;
  assign tick_skip    = pause_on || hold_r;
  assign tick_restart = (stop_cnt != 16'd0) && (stop_inc >= auto_restart);
  assign slow_wait    = slow_on && (slow_inc < slow_factor);
  assign timer_wait   = (dtimer > 16'd1);
  assign hold_time    = (cur_delay == 16'd0) ? 16'd1 : cur_delay;
  assign back_end     = w_frame || (back_i == '0);
  assign out_free     = !m_tvalid || m_tready;

  // saturating adds on the tick total
  logic [TOTAL_W:0] total_add1, total_addd;
  assign total_add1 = {1'b0, total} + (TOTAL_W+1)'(1);
  assign total_addd = {1'b0, total} + (TOTAL_W+1)'(cur_delay);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (in_kind)
            KIND_TICK:                  state_next = S_TICK;
            KIND_RESTART, KIND_MANUAL:  state_next = S_RESTART;
            KIND_STEP_FWD:              state_next = S_WALK_RD;
            KIND_STEP_BACK:             state_next = (slot > 0) ? S_BACK_RD : S_DONE;
            default:                    state_next = S_DONE;
          endcase
        end
      end
      S_RESTART: state_next = S_WALK_RD;
      S_WALK_RD: state_next = S_WALK_EV;
      S_WALK_EV: begin
        if (!walk_end) begin
          state_next = S_WALK_RD;
        end else if (mode == WM_RESET) begin
          state_next = ret_tick ? S_TICK_TAIL : S_TICK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TICK: begin
        if (tick_skip) begin
          state_next = S_DONE;
        end else if (tick_restart) begin
          state_next = S_RESTART;
        end else if (stop_cnt != 16'd0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TICK_TAIL;
        end
      end
      S_TICK_TAIL: state_next = (slow_wait || timer_wait) ? S_DONE : S_WALK_RD;
      S_BACK_RD:   state_next = S_BACK_EV;
      S_BACK_EV:   state_next = back_end ? S_DONE : S_BACK_RD;
      S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    mode_next       = mode;
    ret_tick_next   = ret_tick;
    kind_r_next     = kind_r;
    hold_r_next     = hold_r;
    pos_next        = pos;
    cur_delay_next  = cur_delay;
    dtimer_next     = dtimer;
    sprite_next     = sprite;
    slot_next       = slot;
    stop_cnt_next   = stop_cnt;
    notice_cnt_next = notice_cnt;
    slow_on_next    = slow_on;
    slow_cnt_next   = slow_cnt;
    pause_on_next   = pause_on;
    total_next      = total;
    left_next       = left;
    back_i_next     = back_i;
    redraw_next     = redraw;
    ovf_next        = ovf;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          kind_r_next   = in_kind;
          hold_r_next   = in_hold;
          redraw_next   = 1'b0;
          ovf_next      = 1'b0;
          ret_tick_next = 1'b0;
          case (in_kind)
            KIND_RESTART, KIND_MANUAL: begin
              redraw_next = 1'b1;
            end
            KIND_STEP_FWD: begin
              stop_cnt_next   = 16'd0;
              notice_cnt_next = 8'd0;
              dtimer_next     = 16'd1;
              mode_next       = WM_STEP;
              left_next       = LEFT_W'(MAX_WALK);
              redraw_next     = 1'b1;
            end
            KIND_STEP_BACK: begin
              stop_cnt_next   = 16'd0;
              notice_cnt_next = 8'd0;
              back_i_next     = slot[POS_W-1:0] - POS_W'(1);
            end
            KIND_SLOW_ON: begin
              slow_on_next  = 1'b1;
              slow_cnt_next = 8'd0;
              redraw_next   = 1'b1;
            end
            KIND_SLOW_OFF: begin
              slow_on_next  = 1'b0;
              slow_cnt_next = 8'd0;
              redraw_next   = 1'b1;
            end
            KIND_PAUSE: begin
              pause_on_next = !pause_on;
              redraw_next   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RESTART: begin
        pos_next        = '0;
        cur_delay_next  = 16'(base_delay);
        dtimer_next     = 16'd1;
        sprite_next     = -16'sd1;
        slot_next       = -SLOT_W'(1);
        stop_cnt_next   = 16'd0;
        notice_cnt_next = 8'd0;
        slow_cnt_next   = 8'd0;
        total_next      = '0;
        mode_next       = WM_RESET;
        left_next       = LEFT_W'(MAX_WALK);
      end
      S_WALK_RD: ;
      S_WALK_EV: begin
        left_next = left - LEFT_W'(1);
        if (w_frame) begin
          sprite_next = wd;
          slot_next   = SLOT_W'(pos);
          pos_next    = pos + POS_W'(1);
          dtimer_next = hold_time;
          if (mode == WM_STEP) begin
            total_next = total_addd[TOTAL_W] ? '1 : total_addd[TOTAL_W-1:0];
          end
        end else if (w_restart) begin
          pos_next = '0;
        end else if (w_stop) begin
          if (mode == WM_STEP) begin
            pos_next = '0;
          end else begin
            if (mode == WM_TICK) begin
              dtimer_next = hold_time;
            end
            stop_cnt_next = 16'd1;
          end
        end else if (w_jump) begin
          pos_next = pos - jump_dist[POS_W-1:0];
        end else begin
          cur_delay_next = 16'(-wd);
          pos_next       = pos + POS_W'(1);
        end
        if (walk_ovf) begin
          ovf_next = 1'b1;
        end
        if (walk_end) begin
          case (mode)
            WM_RESET: begin
              if (ret_tick) begin
                ret_tick_next = 1'b0;
              end else if (kind_r == KIND_MANUAL) begin
                notice_cnt_next = manual_notice;
              end
            end
            WM_TICK: begin
              if (walk_ovf) begin
                dtimer_next = 16'd1;
              end
              redraw_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        if (!tick_skip) begin
          if (notice_cnt != 8'd0) begin
            notice_cnt_next = notice_cnt - 8'd1;
            if (notice_cnt == 8'd1) begin
              redraw_next = 1'b1;
            end
          end
          if (stop_cnt != 16'd0) begin
            stop_cnt_next = stop_inc;
            if (tick_restart) begin
              ret_tick_next = 1'b1;
            end else if (stop_inc == stop_notice) begin
              redraw_next = 1'b1;
            end
          end
        end
      end
      S_TICK_TAIL: begin
        if (slow_wait) begin
          slow_cnt_next = slow_inc;
        end else begin
          slow_cnt_next = 8'd0;
          total_next    = total_add1[TOTAL_W] ? '1 : total_add1[TOTAL_W-1:0];
          if (timer_wait) begin
            dtimer_next = dtimer - 16'd1;
          end else begin
            dtimer_next = 16'd0;
            mode_next   = WM_TICK;
            left_next   = LEFT_W'(MAX_WALK);
          end
        end
      end
      S_BACK_RD: ;
      S_BACK_EV: begin
        if (w_frame) begin
          slot_next   = SLOT_W'(back_i);
          sprite_next = wd;
          pos_next    = back_i + POS_W'(1);
          dtimer_next = hold_time;
          total_next  = (total > TOTAL_W'(cur_delay)) ? total - TOTAL_W'(cur_delay) : '0;
          redraw_next = 1'b1;
        end else begin
          back_i_next = back_i - POS_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= WM_RESET;
      ret_tick   <= 1'b0;
      kind_r     <= KIND_TICK;
      hold_r     <= 1'b0;
      pos        <= '0;
      cur_delay  <= 16'(BASE_DELAY_RST);
      dtimer     <= 16'd1;
      sprite     <= -16'sd1;
      slot       <= -SLOT_W'(1);
      stop_cnt   <= 16'd0;
      notice_cnt <= 8'd0;
      slow_on    <= 1'b0;
      slow_cnt   <= 8'd0;
      pause_on   <= 1'b0;
      total      <= '0;
      left       <= '0;
      back_i     <= '0;
      redraw     <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      ret_tick   <= ret_tick_next;
      kind_r     <= kind_r_next;
      hold_r     <= hold_r_next;
      pos        <= pos_next;
      cur_delay  <= cur_delay_next;
      dtimer     <= dtimer_next;
      sprite     <= sprite_next;
      slot       <= slot_next;
      stop_cnt   <= stop_cnt_next;
      notice_cnt <= notice_cnt_next;
      slow_on    <= slow_on_next;
      slow_cnt   <= slow_cnt_next;
      pause_on   <= pause_on_next;
      total      <= total_next;
      left       <= left_next;
      back_i     <= back_i_next;
      redraw     <= redraw_next;
      ovf        <= ovf_next;
    end
  end

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= BASE_DELAY_RST;
      auto_restart  <= AUTO_RESTART_RST;
      stop_notice   <= STOP_NOTICE_RST;
      manual_notice <= MANUAL_NOTICE_RST;
      slow_factor   <= SLOW_FACTOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_DELAY:    base_delay    <= cfg_data[7:0];
        CFG_AUTO_RESTART:  auto_restart  <= cfg_data;
        CFG_STOP_NOTICE:   stop_notice   <= cfg_data;
        CFG_MANUAL_NOTICE: manual_notice <= cfg_data[7:0];
        CFG_SLOW_FACTOR:   slow_factor   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // response register
  logic               notice;
  logic signed [31:0] slot_ext;
  logic               out_load;

  assign notice   = !slow_on && ((notice_cnt != 8'd0) ||
                    ((stop_cnt != 16'd0) && (stop_cnt >= stop_notice)));
  assign slot_ext = 32'(slot);
  assign out_load = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, ovf, redraw, total, notice, (stop_cnt != 16'd0),
                  slot_ext[8:0], sprite};
    end
  end

  `SAS_ASSERT_NOW(a_walk_budget, state == S_WALK_EV, left != '0, "walk ran past its budget")
  `SAS_ASSERT_NEXT(a_busy_after_req, s_fire, !s_tready, "request did not occupy sequencer")
  `SAS_ASSERT_NEXT(a_resp_loaded, out_load, m_tvalid, "response not presented")
  `SAS_ASSERT_NOW(a_slot_range, slot < 0, slot == -SLOT_W'(1), "shown slot below minus one")

endmodule

// ----- rtl/core/sas_ram.sv -----
module sas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
